// ===== design/periodic_task_alarm_scheduler_top_defines.svh =====
// Assertion macros shared by the scheduler RTL.
// Define NO_ASSERTIONS to compile them away.
`ifndef PERIODIC_TASK_ALARM_SCHEDULER_TOP_DEFINES_SVH
`define PERIODIC_TASK_ALARM_SCHEDULER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PTAS_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PTAS_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PTAS_ASSERT(name, prop, msg)
`define PTAS_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

// ===== design/ptas_pkg.sv =====
`default_nettype none
package ptas_pkg;

	localparam int KIND_W     = 2;
	localparam int TASK_W     = 3;
	localparam int TIME_W     = 8;
	localparam int COUNT_W    = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam int MASK_W     = 8;

	typedef enum logic [KIND_W-1:0] {
		KIND_SET_ALARM = 2'd0,
		KIND_TICK      = 2'd1,
		KIND_POP_FAST  = 2'd2,
		KIND_POP_SLOW  = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TICK_DIVIDER = 1'd0,
		CFG_FAST_MASK    = 1'd1
	} cfg_index_t;

	typedef struct packed {
		logic [TIME_W-1:0] period;
		logic [TIME_W-1:0] countdown;
	} alarm_t;

endpackage
`default_nettype wire

// ===== design/ptas_if.sv =====
`default_nettype none
interface ptas_item_if import ptas_pkg::*;;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [TASK_W-1:0] task_req;
	logic [TIME_W-1:0] first_delay;
	logic [TIME_W-1:0] period;

	modport source (output valid, kind, task_req, first_delay, period, input ready);
	modport sink (input valid, kind, task_req, first_delay, period, output ready);
endinterface

interface ptas_result_if import ptas_pkg::*;;
	logic               valid;
	logic               ready;
	logic [TASK_W-1:0]  task_out;
	logic               task_valid;
	logic [COUNT_W-1:0] queued_count;
	logic               overflow;

	modport source (output valid, task_out, task_valid, queued_count, overflow, input ready);
	modport sink (input valid, task_out, task_valid, queued_count, overflow, output ready);
endinterface
`default_nettype wire

// ===== design/ptas_ram.sv =====
`default_nettype none
module ptas_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  wire logic                                         clk,
	input  wire logic                                         we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                             wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== design/periodic_task_alarm_scheduler_top.sv =====
`default_nettype none
// Alarm scheduler for up to TASKS periodic tasks. Each item on the item channel gives exactly
// one transfer on the result channel. A set-alarm item, a tick without a scan and a pop of an
// empty queue reach the output register through the result state; a pop of a non-empty queue
// passes the pop state first. For a tick that triggers a scan, the alarm memory has a single
// read port, so the scan walks the task entries one a cycle, reading one entry while writing
// back the one before. The next item is taken the cycle after a result is loaded. The block
// takes one item at a time; a result waiting in the output register does not stop the next
// item from being taken, but that item's result then waits until the receiver takes the
// earlier one. Alarm countdowns clear at reset through a valid flag per task; the queues start
// empty. Each queue holds one entry fewer than its depth.
`include "periodic_task_alarm_scheduler_top_defines.svh"
module periodic_task_alarm_scheduler_top import ptas_pkg::*; #(
	parameter int TASKS      = 8,
	parameter int FAST_DEPTH = 8,
	parameter int SLOW_DEPTH = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	ptas_item_if.sink                  item,
	ptas_result_if.source              result
);

	localparam int TIDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;
	localparam int SCNT_W = $clog2(TASKS + 1);
	localparam int FPW    = $clog2(FAST_DEPTH);
	localparam int SPW    = $clog2(SLOW_DEPTH);
	localparam int WIDE_W = 7;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_POP,
		ST_RESULT
	} state_t;

	state_t              state_q;
	logic [TIME_W-1:0]   tick_div_q;
	logic [MASK_W-1:0]   fast_mask_q;
	logic [TIME_W-1:0]   prescaler_q;
	logic [TASKS-1:0]    valid_q;
	logic [SCNT_W-1:0]   scan_cnt_q;
	logic                scan_vld_s1;
	logic [TIDX_W-1:0]   scan_idx_s1;
	logic [FPW-1:0]      fast_wp_q;
	logic [FPW-1:0]      fast_rp_q;
	logic [SPW-1:0]      slow_wp_q;
	logic [SPW-1:0]      slow_rp_q;
	logic                pop_fast_q;
	logic [TASK_W-1:0]   res_task_q;
	logic                res_tvalid_q;
	logic [COUNT_W-1:0]  queued_q;
	logic                ovf_q;
	logic                out_valid_q;
	logic [TASK_W-1:0]   out_task_q;
	logic                out_tvalid_q;
	logic [COUNT_W-1:0]  out_queued_q;
	logic                out_ovf_q;

	logic                accept;
	logic                task_ok;
	logic [TIDX_W-1:0]   set_idx;
	logic                set_we;
	logic [TIME_W-1:0]   ps_inc;
	logic                load_res;

	logic                alarm_we;
	logic [TIDX_W-1:0]   alarm_waddr;
	alarm_t              alarm_wdata;
	alarm_t              alarm_rdata;
	logic [TIME_W-1:0]   cur_cd;
	logic                scan_we;
	logic                expire;
	logic [WIDE_W-1:0]   idx_wide;
	logic                to_fast;

	logic [FPW-1:0]      fast_wp_next;
	logic [FPW-1:0]      fast_rp_next;
	logic                fast_full;
	logic                fast_empty;
	logic                fast_push;
	logic [TASK_W-1:0]   fast_rdata;
	logic [SPW-1:0]      slow_wp_next;
	logic [SPW-1:0]      slow_rp_next;
	logic                slow_full;
	logic                slow_empty;
	logic                slow_push;
	logic [TASK_W-1:0]   slow_rdata;
	logic                scan_drop;

	assign accept  = item.valid && item.ready;
	assign task_ok = int'(item.task_req) < TASKS;
	assign set_idx = TIDX_W'(item.task_req);
	assign set_we  = accept && (kind_t'(item.kind) == KIND_SET_ALARM) && task_ok;
	assign ps_inc  = prescaler_q + 1'b1;
	assign load_res = (state_q == ST_RESULT) && (!out_valid_q || result.ready);

	// An entry never written since reset counts as an idle alarm.
	assign cur_cd   = valid_q[scan_idx_s1] ? alarm_rdata.countdown : '0;
	assign scan_we  = scan_vld_s1 && (cur_cd != '0);
	assign expire   = scan_vld_s1 && (cur_cd == TIME_W'(1));
	assign idx_wide = WIDE_W'(scan_idx_s1);
	assign to_fast  = (idx_wide < WIDE_W'(8)) && fast_mask_q[idx_wide[2:0]];

	assign fast_wp_next = (fast_wp_q == FPW'(FAST_DEPTH - 1)) ? '0 : fast_wp_q + 1'b1;
	assign fast_rp_next = (fast_rp_q == FPW'(FAST_DEPTH - 1)) ? '0 : fast_rp_q + 1'b1;
	assign fast_full    = fast_wp_next == fast_rp_q;
	assign fast_empty   = fast_wp_q == fast_rp_q;
	assign slow_wp_next = (slow_wp_q == SPW'(SLOW_DEPTH - 1)) ? '0 : slow_wp_q + 1'b1;
	assign slow_rp_next = (slow_rp_q == SPW'(SLOW_DEPTH - 1)) ? '0 : slow_rp_q + 1'b1;
	assign slow_full    = slow_wp_next == slow_rp_q;
	assign slow_empty   = slow_wp_q == slow_rp_q;

	assign fast_push = expire && to_fast && !fast_full;
	assign slow_push = expire && !to_fast && !slow_full;
	assign scan_drop = expire && (to_fast ? fast_full : slow_full);

	always_comb begin
		alarm_we    = set_we || scan_we;
		alarm_waddr = set_idx;
		alarm_wdata = '{period: item.period, countdown: item.first_delay};
		if (scan_vld_s1) begin
			alarm_waddr = scan_idx_s1;
			alarm_wdata.period = alarm_rdata.period;
			alarm_wdata.countdown = expire ? alarm_rdata.period : cur_cd - 1'b1;
		end
	end

	ptas_ram #(.WIDTH($bits(alarm_t)), .DEPTH(TASKS)) u_alarm_ram (
		.clk   (clk),
		.we    (alarm_we),
		.waddr (alarm_waddr),
		.wdata (alarm_wdata),
		.raddr (scan_cnt_q[TIDX_W-1:0]),
		.rdata (alarm_rdata)
	);

	ptas_ram #(.WIDTH(TASK_W), .DEPTH(FAST_DEPTH)) u_fast_ram (
		.clk   (clk),
		.we    (fast_push),
		.waddr (fast_wp_next),
		.wdata (idx_wide[TASK_W-1:0]),
		.raddr (fast_rp_next),
		.rdata (fast_rdata)
	);

	ptas_ram #(.WIDTH(TASK_W), .DEPTH(SLOW_DEPTH)) u_slow_ram (
		.clk   (clk),
		.we    (slow_push),
		.waddr (slow_wp_next),
		.wdata (idx_wide[TASK_W-1:0]),
		.raddr (slow_rp_next),
		.rdata (slow_rdata)
	);

	assign item.ready          = state_q == ST_IDLE;
	assign result.valid        = out_valid_q;
	assign result.task_out     = out_task_q;
	assign result.task_valid   = out_tvalid_q;
	assign result.queued_count = out_queued_q;
	assign result.overflow     = out_ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			tick_div_q   <= TIME_W'(1);
			fast_mask_q  <= '0;
			prescaler_q  <= '0;
			valid_q      <= '0;
			scan_cnt_q   <= '0;
			scan_vld_s1  <= 1'b0;
			scan_idx_s1  <= '0;
			fast_wp_q    <= FPW'(FAST_DEPTH - 1);
			fast_rp_q    <= FPW'(FAST_DEPTH - 1);
			slow_wp_q    <= SPW'(SLOW_DEPTH - 1);
			slow_rp_q    <= SPW'(SLOW_DEPTH - 1);
			pop_fast_q   <= 1'b0;
			res_task_q   <= '0;
			res_tvalid_q <= 1'b0;
			queued_q     <= '0;
			ovf_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			out_task_q   <= '0;
			out_tvalid_q <= 1'b0;
			out_queued_q <= '0;
			out_ovf_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index_t'(cfg_index))
					CFG_TICK_DIVIDER: tick_div_q <= cfg_data;
					CFG_FAST_MASK:    fast_mask_q <= cfg_data;
					default: ;
				endcase
			end
			if (load_res) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (set_we) begin
				valid_q[set_idx] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_task_q   <= '0;
						res_tvalid_q <= 1'b0;
						queued_q     <= '0;
						ovf_q        <= 1'b0;
						case (kind_t'(item.kind))
							KIND_SET_ALARM: state_q <= ST_RESULT;
							KIND_TICK: begin
								if (ps_inc == tick_div_q) begin
									prescaler_q <= '0;
									scan_cnt_q  <= '0;
									state_q     <= ST_SCAN;
								end else begin
									prescaler_q <= ps_inc;
									state_q     <= ST_RESULT;
								end
							end
							KIND_POP_FAST: begin
								pop_fast_q <= 1'b1;
								if (!fast_empty) begin
									fast_rp_q <= fast_rp_next;
									state_q   <= ST_POP;
								end else begin
									state_q <= ST_RESULT;
								end
							end
							default: begin
								pop_fast_q <= 1'b0;
								if (!slow_empty) begin
									slow_rp_q <= slow_rp_next;
									state_q   <= ST_POP;
								end else begin
									state_q <= ST_RESULT;
								end
							end
						endcase
					end
				end
				ST_SCAN: begin
					// Read of entry n overlaps the write-back of entry n-1.
					if (scan_cnt_q != SCNT_W'(TASKS)) begin
						scan_cnt_q  <= scan_cnt_q + 1'b1;
						scan_vld_s1 <= 1'b1;
						scan_idx_s1 <= scan_cnt_q[TIDX_W-1:0];
					end else begin
						scan_vld_s1 <= 1'b0;
						if (!scan_vld_s1) begin
							state_q <= ST_RESULT;
						end
					end
					if (fast_push) begin
						fast_wp_q <= fast_wp_next;
					end
					if (slow_push) begin
						slow_wp_q <= slow_wp_next;
					end
					if ((fast_push || slow_push) && (queued_q != '1)) begin
						queued_q <= queued_q + 1'b1;
					end
					if (scan_drop) begin
						ovf_q <= 1'b1;
					end
				end
				ST_POP: begin
					res_task_q   <= pop_fast_q ? fast_rdata : slow_rdata;
					res_tvalid_q <= 1'b1;
					state_q      <= ST_RESULT;
				end
				ST_RESULT: begin
					if (load_res) begin
						out_task_q   <= res_task_q;
						out_tvalid_q <= res_tvalid_q;
						out_queued_q <= queued_q;
						out_ovf_q    <= ovf_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`PTAS_ASSERT_ALWAYS(a_ptr_range, (int'(fast_wp_q) < FAST_DEPTH) && (int'(slow_wp_q) < SLOW_DEPTH), "queue write pointer out of range")
	`PTAS_ASSERT(a_push_not_empty, fast_push |=> (fast_wp_q != fast_rp_q), "fast queue empty after a push")
	`PTAS_ASSERT(a_result_from_result_state, $rose(out_valid_q) |-> $past(state_q == ST_RESULT), "result loaded outside result state")
	`PTAS_ASSERT(a_pop_result_clean, (out_valid_q && out_tvalid_q) |-> ((out_queued_q == '0) && !out_ovf_q), "pop result carries scan fields")
	`PTAS_ASSERT(a_scan_stage_idle, (state_q != ST_SCAN) |-> !scan_vld_s1, "scan stage busy outside a scan")

endmodule
`default_nettype wire
